[hw/rtl/pdlz_pkg.sv]
// ----------------------------------------------------------------------------
// pdlz_pkg
// Shared constants for the PalmDoc LZ77 decompressor: window size, token
// byte ranges, the copy length base and the status codes of a result item.
// ----------------------------------------------------------------------------
package pdlz_pkg;

  localparam int PDLZ_WINDOW_SIZE = 2048;
  localparam int PDLZ_DIST_W      = 11;

  localparam logic [7:0] PDLZ_RUN_MIN    = 8'h01;
  localparam logic [7:0] PDLZ_RUN_MAX    = 8'h08;
  localparam logic [7:0] PDLZ_PAIR_MIN   = 8'h80;
  localparam logic [7:0] PDLZ_PAIR_MAX   = 8'hBF;
  localparam logic [7:0] PDLZ_SPACE_MIN  = 8'hC0;
  localparam logic [7:0] PDLZ_SPACE_CHAR = 8'h20;
  localparam logic [7:0] PDLZ_FLIP_MASK  = 8'h80;
  localparam logic [3:0] PDLZ_LEN_BASE   = 4'd3;

  localparam logic [1:0] PDLZ_ST_OK    = 2'd0;
  localparam logic [1:0] PDLZ_ST_DIST  = 2'd1;
  localparam logic [1:0] PDLZ_ST_TRUNC = 2'd2;

endpackage

[hw/rtl/palmdoc_lz77_decompressor_top.sv]
// A byte is taken only in the idle state; each result goes to the registered
// output stage, and a back-reference first issues a history memory read.
// Items: none per token with no output, one per literal or bad distance, two
// per space pair, length (3 to 10) per back-reference, plus one per truncation.
// Input waits for each token to finish; the single read port sets copy rate.
// Reset is synchronous; the history memory is not cleared and needs no pass.
// ----------------------------------------------------------------------------
// palmdoc_lz77_decompressor_top
// Byte-serial PalmDoc LZ77 decoder: a small sequencer drives one shared
// history put unit and a copy read port, with a registered output stage.
// ----------------------------------------------------------------------------
module palmdoc_lz77_decompressor_top
  import pdlz_pkg::*;
#(
  parameter int WINDOW_SIZE = PDLZ_WINDOW_SIZE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] record_start
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [1:0] status
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam int CW = AW + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_TRUNC   = 3'd1;
  localparam logic [2:0] S_ONE     = 3'd2;
  localparam logic [2:0] S_SPACE   = 3'd3;
  localparam logic [2:0] S_ERR     = 3'd4;
  localparam logic [2:0] S_COPY_RD = 3'd5;
  localparam logic [2:0] S_COPY_EM = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    after_r, after_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic          dist1_r, dist1_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] bp_r, bp_nxt;
  logic [3:0]    lit_r, lit_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    high_r, high_nxt;
  logic [7:0]    last_byte_r, last_byte_nxt;

  logic          ov_r, ov_nxt;
  logic [7:0]    od_r, od_nxt;
  logic          ol_r, ol_nxt;
  logic [1:0]    os_r, os_nxt;

  logic          put;
  logic [7:0]    put_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          out_free;

  logic [3:0]             lit_e;
  logic                   pend_e;
  logic [7:0]             high_e;
  logic [CW-1:0]          bp_e;
  logic [AW-1:0]          wp_e;
  logic                   open_rec;
  logic [15:0]            word;
  logic [PDLZ_DIST_W-1:0] copy_dist;
  logic [2:0]             act;
  logic [7:0]             copy_byte;

  pdlz_hist_ram #(
    .DEPTH(WINDOW_SIZE)
  ) u_hist (
    .clk    (clk),
    .wr_en  (put),
    .wr_addr(wp_r),
    .wr_data(put_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_free  = !ov_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign copy_byte = dist1_r ? last_byte_r : rd_data;

  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    byte_nxt      = byte_r;
    cnt_nxt       = cnt_r;
    src_nxt       = src_r;
    dist1_nxt     = dist1_r;
    wp_nxt        = wp_r;
    bp_nxt        = bp_r;
    lit_nxt       = lit_r;
    pend_nxt      = pend_r;
    high_nxt      = high_r;
    last_byte_nxt = last_byte_r;
    ov_nxt        = ov_r && !out_tready;
    od_nxt        = od_r;
    ol_nxt        = ol_r;
    os_nxt        = os_r;
    put           = 1'b0;
    put_data      = byte_r;
    rd_en         = 1'b0;
    rd_addr       = src_r;
    lit_e         = in_tuser ? 4'd0 : lit_r;
    pend_e        = in_tuser ? 1'b0 : pend_r;
    high_e        = in_tuser ? 8'd0 : high_r;
    bp_e          = in_tuser ? '0 : bp_r;
    wp_e          = in_tuser ? '0 : wp_r;
    open_rec      = in_tuser && (lit_r != 4'd0 || pend_r);
    word          = {high_e, in_tdata};
    copy_dist     = word[PDLZ_DIST_W+2:3];
    act           = S_IDLE;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          lit_nxt  = lit_e;
          pend_nxt = pend_e;
          high_nxt = high_e;
          bp_nxt   = bp_e;
          wp_nxt   = wp_e;
          if (lit_e != 4'd0) begin
            lit_nxt  = lit_e - 4'd1;
            byte_nxt = in_tdata;
            act      = S_ONE;
          end else if (pend_e) begin
            pend_nxt = 1'b0;
            high_nxt = 8'd0;
            if (copy_dist == '0 || CW'(copy_dist) > bp_e) begin
              act = S_ERR;
            end else begin
              act       = S_COPY_RD;
              cnt_nxt   = {1'b0, word[2:0]} + PDLZ_LEN_BASE;
              src_nxt   = wp_e - AW'(copy_dist);
              dist1_nxt = (copy_dist == PDLZ_DIST_W'(1));
            end
          end else if (in_tdata >= PDLZ_RUN_MIN && in_tdata <= PDLZ_RUN_MAX) begin
            lit_nxt = in_tdata[3:0];
          end else if (in_tdata >= PDLZ_PAIR_MIN && in_tdata <= PDLZ_PAIR_MAX) begin
            pend_nxt = 1'b1;
            high_nxt = in_tdata;
          end else if (in_tdata >= PDLZ_SPACE_MIN) begin
            byte_nxt = in_tdata ^ PDLZ_FLIP_MASK;
            act      = S_SPACE;
          end else begin
            byte_nxt = in_tdata;
            act      = S_ONE;
          end
          if (open_rec) begin
            state_nxt = S_TRUNC;
            after_nxt = act;
          end else begin
            state_nxt = act;
          end
        end
      end
      S_TRUNC: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt    = 8'd0;
          ol_nxt    = (after_r == S_IDLE);
          os_nxt    = PDLZ_ST_TRUNC;
          state_nxt = after_r;
        end
      end
      S_ONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt    = byte_r;
          ol_nxt    = 1'b1;
          os_nxt    = PDLZ_ST_OK;
          put       = 1'b1;
          put_data  = byte_r;
          state_nxt = S_IDLE;
        end
      end
      S_SPACE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt    = PDLZ_SPACE_CHAR;
          ol_nxt    = 1'b0;
          os_nxt    = PDLZ_ST_OK;
          put       = 1'b1;
          put_data  = PDLZ_SPACE_CHAR;
          state_nxt = S_ONE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt    = 8'd0;
          ol_nxt    = 1'b1;
          os_nxt    = PDLZ_ST_DIST;
          state_nxt = S_IDLE;
        end
      end
      S_COPY_RD: begin
        rd_en     = 1'b1;
        rd_addr   = src_r;
        state_nxt = S_COPY_EM;
      end
      S_COPY_EM: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          od_nxt   = copy_byte;
          ol_nxt   = (cnt_r == 4'd1);
          os_nxt   = PDLZ_ST_OK;
          put      = 1'b1;
          put_data = copy_byte;
          cnt_nxt  = cnt_r - 4'd1;
          src_nxt  = src_r + AW'(1);
          if (cnt_r == 4'd1) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = src_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (put) begin
      wp_nxt        = wp_r + AW'(1);
      last_byte_nxt = put_data;
      if (bp_r != CW'(WINDOW_SIZE)) begin
        bp_nxt = bp_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= S_IDLE;
      wp_r    <= '0;
      bp_r    <= '0;
      lit_r   <= 4'd0;
      pend_r  <= 1'b0;
      high_r  <= 8'd0;
      cnt_r   <= 4'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      wp_r    <= wp_nxt;
      bp_r    <= bp_nxt;
      lit_r   <= lit_nxt;
      pend_r  <= pend_nxt;
      high_r  <= high_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    src_r       <= src_nxt;
    dist1_r     <= dist1_nxt;
    last_byte_r <= last_byte_nxt;
    od_r        <= od_nxt;
    ol_r        <= ol_nxt;
    os_r        <= os_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = os_r;

endmodule

[hw/rtl/pdlz_hist_ram.sv]
// ----------------------------------------------------------------------------
// pdlz_hist_ram
// History window memory: one write port and one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module pdlz_hist_ram
  import pdlz_pkg::*;
#(
  parameter int DEPTH = PDLZ_WINDOW_SIZE
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
